// ----- sv/arsel_pkg.sv -----
// ----------------------------------------------------------------------------
// arsel_pkg
// Shared types, constants and helpers for the ADC auto range selector.
// ----------------------------------------------------------------------------
package arsel_pkg;

	localparam int SAMPLES_PER_CHUNK = 64;
	localparam int COOLDOWN_CHUNKS   = 4;

	localparam int CODE_W = 12;
	localparam int CNT_W  = 8;
	localparam int CD_W   = 8;
	localparam int POS_W  = $clog2(SAMPLES_PER_CHUNK + 1);
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [CODE_W-1:0] CODE_MAX = 12'd4095;
	localparam logic [CNT_W-1:0]  CNT_MAX  = 8'd255;

	typedef enum logic [1:0] {
		RANGE_LOW  = 2'd0,
		RANGE_MID  = 2'd1,
		RANGE_HIGH = 2'd2,
		MODE_AUTO  = 2'd3
	} range_t;

	// register indexes (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_RANGE_MODE    = 3'd0,
		REG_LOW_OVER      = 3'd1,
		REG_MID_OVER      = 3'd2,
		REG_MID_UNDER     = 3'd3,
		REG_HIGH_UNDER    = 3'd4,
		REG_RAIL_MARGIN   = 3'd5,
		REG_UP_CONFIRM    = 3'd6,
		REG_DOWN_CONFIRM  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]        range_mode;
		logic [CODE_W-1:0] low_over;
		logic [CODE_W-1:0] mid_over;
		logic [CODE_W-1:0] mid_under;
		logic [CODE_W-1:0] high_under;
		logic [10:0]       rail_margin;
		logic [CNT_W-1:0]  up_confirm;
		logic [CNT_W-1:0]  down_confirm;
	} cfg_t;

	typedef struct packed {
		logic [CODE_W-1:0] vol;
		logic [CODE_W-1:0] lo;
		logic [CODE_W-1:0] mid;
		logic [CODE_W-1:0] hi;
		logic [CODE_W-1:0] ref_c;
	} row_t;

	typedef struct packed {
		logic              sample_valid;
		logic [1:0]        sample_range;
		logic [CODE_W-1:0] vol;
		logic [CODE_W-1:0] cur;
		logic [CODE_W-1:0] ref_c;
		logic              route_change;
		logic [1:0]        new_range;
		logic              packet_end;
	} res_t;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
	endfunction

	function automatic logic [CODE_W-1:0] abs_diff(input logic [CODE_W-1:0] a,
			input logic [CODE_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

endpackage

// ----- sv/arsel_regs.sv -----
// ----------------------------------------------------------------------------
// arsel_regs
// APB register file holding the ranging thresholds and mode.
// ----------------------------------------------------------------------------
module arsel_regs import arsel_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_mode   <= MODE_AUTO;
			cfg_q.low_over     <= 12'd3800;
			cfg_q.mid_over     <= 12'd3800;
			cfg_q.mid_under    <= 12'd200;
			cfg_q.high_under   <= 12'd200;
			cfg_q.rail_margin  <= 11'd200;
			cfg_q.up_confirm   <= 8'd4;
			cfg_q.down_confirm <= 8'd16;
		end else if (wr_en) begin
			case (idx)
				REG_RANGE_MODE:   cfg_q.range_mode   <= pwdata[1:0];
				REG_LOW_OVER:     cfg_q.low_over     <= pwdata[CODE_W-1:0];
				REG_MID_OVER:     cfg_q.mid_over     <= pwdata[CODE_W-1:0];
				REG_MID_UNDER:    cfg_q.mid_under    <= pwdata[CODE_W-1:0];
				REG_HIGH_UNDER:   cfg_q.high_under   <= pwdata[CODE_W-1:0];
				REG_RAIL_MARGIN:  cfg_q.rail_margin  <= pwdata[10:0];
				REG_UP_CONFIRM:   cfg_q.up_confirm   <= pwdata[CNT_W-1:0];
				REG_DOWN_CONFIRM: cfg_q.down_confirm <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RANGE_MODE:   prdata = DATA_W'(cfg_q.range_mode);
			REG_LOW_OVER:     prdata = DATA_W'(cfg_q.low_over);
			REG_MID_OVER:     prdata = DATA_W'(cfg_q.mid_over);
			REG_MID_UNDER:    prdata = DATA_W'(cfg_q.mid_under);
			REG_HIGH_UNDER:   prdata = DATA_W'(cfg_q.high_under);
			REG_RAIL_MARGIN:  prdata = DATA_W'(cfg_q.rail_margin);
			REG_UP_CONFIRM:   prdata = DATA_W'(cfg_q.up_confirm);
			REG_DOWN_CONFIRM: prdata = DATA_W'(cfg_q.down_confirm);
			default:          prdata = '0;
		endcase
	end

endmodule

// ----- sv/arsel_decide.sv -----
// ----------------------------------------------------------------------------
// arsel_decide
// Range decision logic and chunk / cooldown state, one row per step.
// ----------------------------------------------------------------------------
module arsel_decide import arsel_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  row_t row,
	input  logic step,
	output logic has_result,
	output res_t res
);

	logic [1:0]       active_q;
	logic [CNT_W-1:0] up_q, down_q;
	logic             skip_next_q;
	logic [CD_W-1:0]  cooldown_q;
	logic [POS_W-1:0] pos_q;
	logic             dropping_q, skipping_q;

	logic             pos0, last, skipping_e, dropping_e, force_now, forced, drop;
	logic             auto_ok, over, under, rail, sw;
	logic [1:0]       range_a, req;
	logic [CNT_W-1:0] up_a, down_a, up_n, down_n;
	logic [CODE_W-1:0] d_lo, d_mid, d_hi, cur;
	logic [CODE_W-1:0] margin;

	assign pos0 = (pos_q == '0);
	assign last = (pos_q == POS_W'(SAMPLES_PER_CHUNK - 1));
	assign skipping_e = pos0 ? skip_next_q : skipping_q;
	assign dropping_e = pos0 ? 1'b0 : dropping_q;
	assign drop = skipping_e || dropping_e;

	// fixed mode forces the route at the start of a chunk that is kept
	assign force_now = pos0 && !skipping_e && (cfg.range_mode != MODE_AUTO);
	assign forced    = force_now && (active_q != cfg.range_mode);
	assign range_a   = force_now ? cfg.range_mode : active_q;
	assign up_a      = force_now ? '0 : up_q;
	assign down_a    = force_now ? '0 : down_q;

	assign auto_ok = (cfg.range_mode == MODE_AUTO) && (cooldown_q == '0);

	assign d_lo   = abs_diff(row.lo, row.ref_c);
	assign d_mid  = abs_diff(row.mid, row.ref_c);
	assign d_hi   = abs_diff(row.hi, row.ref_c);
	assign margin = CODE_W'(cfg.rail_margin);
	assign rail   = (row.mid >= CODE_MAX - margin) || (row.mid <= margin);

	always_comb begin
		over   = 1'b0;
		under  = 1'b0;
		up_n   = '0;
		down_n = '0;
		req    = range_a;
		case (range_a)
			RANGE_LOW: begin
				over = d_lo >= cfg.low_over;
				up_n = over ? bump(up_a) : '0;
				if (over && up_n >= cfg.up_confirm)
					req = RANGE_MID;
			end
			RANGE_MID: begin
				over   = (d_mid >= cfg.mid_over) || rail;
				under  = d_mid <= cfg.mid_under;
				up_n   = over ? bump(up_a) : '0;
				down_n = under ? bump(down_a) : '0;
				// stepping down takes priority
				if (under && down_n >= cfg.down_confirm)
					req = RANGE_LOW;
				else if (over && up_n >= cfg.up_confirm)
					req = RANGE_HIGH;
			end
			default: begin
				under  = d_hi <= cfg.high_under;
				down_n = under ? bump(down_a) : '0;
				if (under && down_n >= cfg.down_confirm)
					req = RANGE_MID;
			end
		endcase
	end

	assign sw = !drop && auto_ok && (req != range_a);

	always_comb begin
		case (range_a)
			RANGE_LOW: cur = row.lo;
			RANGE_MID: cur = row.mid;
			default:   cur = row.hi;
		endcase
	end

	assign has_result = !drop;

	always_comb begin
		if (sw) begin
			res.sample_valid = 1'b0;
			res.sample_range = range_a;
			res.vol          = '0;
			res.cur          = '0;
			res.ref_c        = '0;
			res.route_change = 1'b1;
			res.new_range    = req;
			res.packet_end   = 1'b1;
		end else begin
			res.sample_valid = 1'b1;
			res.sample_range = range_a;
			res.vol          = row.vol;
			res.cur          = cur;
			res.ref_c        = row.ref_c;
			res.route_change = forced;
			res.new_range    = range_a;
			res.packet_end   = last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= RANGE_HIGH;
			up_q        <= '0;
			down_q      <= '0;
			skip_next_q <= 1'b0;
			cooldown_q  <= '0;
			pos_q       <= '0;
			dropping_q  <= 1'b0;
			skipping_q  <= 1'b0;
		end else if (step) begin
			pos_q      <= last ? '0 : pos_q + POS_W'(1);
			skipping_q <= skipping_e;
			if (sw) begin
				active_q    <= req;
				up_q        <= '0;
				down_q      <= '0;
				skip_next_q <= 1'b1;
				cooldown_q  <= CD_W'(COOLDOWN_CHUNKS);
				dropping_q  <= !last;
			end else begin
				active_q    <= range_a;
				skip_next_q <= pos0 ? 1'b0 : skip_next_q;
				dropping_q  <= dropping_e;
				if (!drop && auto_ok) begin
					up_q   <= up_n;
					down_q <= down_n;
				end else begin
					up_q   <= up_a;
					down_q <= down_a;
				end
				// cooldown counts fully kept chunks
				if (!drop && last && cooldown_q != '0)
					cooldown_q <= cooldown_q - CD_W'(1);
			end
		end
	end

endmodule

// ----- sv/adc_auto_range_selector_core.sv -----
// ----------------------------------------------------------------------------
// adc_auto_range_selector_core
// Auto-ranging current meter front end with hysteresis and chunk skipping.
// ----------------------------------------------------------------------------
// Takes one ADC row per word and returns at most one result word per row,
// with full throughput: a new row is accepted every cycle unless out_ready
// holds a pending result word. Each row passes the input register, then the
// decision logic into the output register; the single range decision between
// the two registers also updates the count, chunk and cooldown state.
// Dropped rows produce no result. Configure only while the block is idle;
// pready is always high.
module adc_auto_range_selector_core import arsel_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CODE_W-1:0] vol_code,
	input  logic [CODE_W-1:0] low_code,
	input  logic [CODE_W-1:0] mid_code,
	input  logic [CODE_W-1:0] high_code,
	input  logic [CODE_W-1:0] ref_code,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              sample_valid,
	output logic [1:0]        sample_range,
	output logic [CODE_W-1:0] out_vol_code,
	output logic [CODE_W-1:0] cur_code,
	output logic [CODE_W-1:0] out_ref_code,
	output logic              route_change,
	output logic [1:0]        new_range,
	output logic              packet_end
);

	cfg_t cfg;
	row_t row_s1;
	logic valid_s1;
	res_t res, res_s2;
	logic valid_s2;
	logic has_result, advance;

	arsel_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			row_s1 <= '{vol: vol_code, lo: low_code, mid: mid_code, hi: high_code,
				ref_c: ref_code};
		end
	end

	arsel_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.row       (row_s1),
		.step      (advance),
		.has_result(has_result),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= has_result;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result)
			res_s2 <= res;
	end

	assign out_valid    = valid_s2;
	assign sample_valid = res_s2.sample_valid;
	assign sample_range = res_s2.sample_range;
	assign out_vol_code = res_s2.vol;
	assign cur_code     = res_s2.cur;
	assign out_ref_code = res_s2.ref_c;
	assign route_change = res_s2.route_change;
	assign new_range    = res_s2.new_range;
	assign packet_end   = res_s2.packet_end;

endmodule

// ----- sv/arsel_checker.sv -----
// ----------------------------------------------------------------------------
// arsel_checker
// Port-level checks on the result channel of the auto range selector.
// ----------------------------------------------------------------------------
module arsel_checker import arsel_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic              sample_valid,
	input logic [1:0]        sample_range,
	input logic [CODE_W-1:0] out_vol_code,
	input logic [CODE_W-1:0] cur_code,
	input logic [CODE_W-1:0] out_ref_code,
	input logic              route_change,
	input logic [1:0]        new_range,
	input logic              packet_end
);

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_valid) &&
		$stable(sample_range) && $stable(cur_code) && $stable(new_range) &&
		$stable(route_change) && $stable(packet_end))
		else $error("result word changed while stalled");

	// a switch word carries no sample and closes the packet
	a_switch_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sample_valid |-> route_change && packet_end &&
		out_vol_code == '0 && cur_code == '0 && out_ref_code == '0 &&
		new_range != sample_range)
		else $error("malformed switch word");

	a_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !route_change |-> new_range == sample_range)
		else $error("new_range differs without route change");

	a_range_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample_range != MODE_AUTO && new_range != MODE_AUTO)
		else $error("illegal range code on output");

endmodule

bind adc_auto_range_selector_core arsel_checker u_arsel_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.sample_valid(sample_valid),
	.sample_range(sample_range),
	.out_vol_code(out_vol_code),
	.cur_code    (cur_code),
	.out_ref_code(out_ref_code),
	.route_change(route_change),
	.new_range   (new_range),
	.packet_end  (packet_end)
);
